// ----- rtl/vfc_pkg.sv -----
// shared types and constants of the view frustum culling test
package vfc_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int COORD_BITS  = 32;
   localparam int HALF_BITS   = COORD_BITS - 1;
   localparam int MODE_BITS   = 3;
   localparam int SLOT_BITS   = 3;
   localparam int IDX_BITS    = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   // offsets and radii are scaled by 2^30 to line up with the Q2.30 products
   localparam int DSHIFT      = 30;
   localparam int CORNER_BITS = COORD_BITS + 1;
   localparam int PROD_BITS   = COORD_BITS + CORNER_BITS;
   localparam int WIDE_BITS   = (PROD_BITS > COORD_BITS + DSHIFT) ?
                                PROD_BITS : COORD_BITS + DSHIFT;
   localparam int SUM_BITS    = WIDE_BITS + 3;

   localparam logic [MODE_BITS-1:0] MODE_POINT  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_SPHERE = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_CUBE   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_BOX    = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_LOAD   = 3'd4;

   typedef enum logic [1:0] {
      OP_TEST,
      OP_LOAD,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DRAIN,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a;
      logic signed [COORD_BITS-1:0] b;
      logic signed [COORD_BITS-1:0] c;
      logic signed [COORD_BITS-1:0] d;
   } plane_type;

   // classified command between the front and back parts
   typedef struct packed {
      op_type                       op;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
      logic [HALF_BITS-1:0]         hx;
      logic [HALF_BITS-1:0]         hy;
      logic [HALF_BITS-1:0]         hz;
      logic [HALF_BITS-1:0]         radius;
      logic [SLOT_BITS-1:0]         slot;
      plane_type                    plane;
   } cmd_type;

endpackage

// ----- rtl/vfc_if.sv -----
// request and response channel interfaces
interface vfc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [vfc_pkg::MODE_BITS-1:0]         mode;
   logic signed [vfc_pkg::COORD_BITS-1:0] center_x;
   logic signed [vfc_pkg::COORD_BITS-1:0] center_y;
   logic signed [vfc_pkg::COORD_BITS-1:0] center_z;
   logic [vfc_pkg::HALF_BITS-1:0]         half_x;
   logic [vfc_pkg::HALF_BITS-1:0]         half_y;
   logic [vfc_pkg::HALF_BITS-1:0]         half_z;
   logic [vfc_pkg::SLOT_BITS-1:0]         plane_slot;
   logic signed [vfc_pkg::COORD_BITS-1:0] plane_a;
   logic signed [vfc_pkg::COORD_BITS-1:0] plane_b;
   logic signed [vfc_pkg::COORD_BITS-1:0] plane_c;
   logic signed [vfc_pkg::COORD_BITS-1:0] plane_d;

   modport source (output valid, mode, center_x, center_y, center_z, half_x, half_y,
                   half_z, plane_slot, plane_a, plane_b, plane_c, plane_d, input ready);
   modport sink (input valid, mode, center_x, center_y, center_z, half_x, half_y,
                 half_z, plane_slot, plane_a, plane_b, plane_c, plane_d, output ready);
endinterface

interface vfc_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink (input valid, visible, output ready);
endinterface

// ----- rtl/vfc_front.sv -----
// front part: classifies request beats and queues commands
module vfc_front (
   input  logic             clock,
   input  logic             reset,
   vfc_req_if.sink          req,
   output vfc_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_pop
);

   vfc_pkg::cmd_type cls;
   vfc_pkg::cmd_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;

   // corner half sizes: zero for point and sphere, replicated for cube
   always_comb begin
      cls        = '0;
      cls.cx     = req.center_x;
      cls.cy     = req.center_y;
      cls.cz     = req.center_z;
      cls.slot   = req.plane_slot;
      cls.plane  = '{a: req.plane_a, b: req.plane_b, c: req.plane_c, d: req.plane_d};
      case (req.mode)
         vfc_pkg::MODE_POINT: begin
            cls.op = vfc_pkg::OP_TEST;
         end
         vfc_pkg::MODE_SPHERE: begin
            cls.op     = vfc_pkg::OP_TEST;
            cls.radius = req.half_x;
         end
         vfc_pkg::MODE_CUBE: begin
            cls.op = vfc_pkg::OP_TEST;
            cls.hx = req.half_x;
            cls.hy = req.half_x;
            cls.hz = req.half_x;
         end
         vfc_pkg::MODE_BOX: begin
            cls.op = vfc_pkg::OP_TEST;
            cls.hx = req.half_x;
            cls.hy = req.half_y;
            cls.hz = req.half_z;
         end
         vfc_pkg::MODE_LOAD: begin
            cls.op = vfc_pkg::OP_LOAD;
         end
         default: begin
            cls.op = vfc_pkg::OP_NONE;
         end
      endcase
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/vfc_back.sv -----
// back part: plane table, plane sequencer and distance datapath
module vfc_back (
   input  logic             clock,
   input  logic             reset,
   input  vfc_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   vfc_rsp_if.source        rsp
);

   localparam int C = vfc_pkg::COORD_BITS;
   localparam int W = vfc_pkg::CORNER_BITS;
   localparam int P = vfc_pkg::PROD_BITS;
   localparam int S = vfc_pkg::SUM_BITS;

   vfc_pkg::back_state_type state_ff, state_in;
   vfc_pkg::plane_type      tab_ff [vfc_pkg::PLANE_COUNT];
   vfc_pkg::plane_type      pl;
   vfc_pkg::cmd_type        job_ff;
   logic [vfc_pkg::IDX_BITS-1:0] idx_ff;
   logic                    last_idx;
   logic                    issue;
   logic                    slot_ok;
   logic                    vis_ff;
   logic                    s1_vld_ff, s2_vld_ff;
   logic signed [C-1:0]     s1_a_ff, s1_b_ff, s1_c_ff;
   logic signed [W-1:0]     s1_px_ff, s1_py_ff, s1_pz_ff;
   logic signed [W-1:0]     px_in, py_in, pz_in;
   logic signed [S-1:0]     off_in, s1_off_ff, s2_off_ff;
   logic signed [P-1:0]     s2_p0_ff, s2_p1_ff, s2_p2_ff;
   logic signed [S-1:0]     dist_sum;

   assign last_idx = (idx_ff == vfc_pkg::IDX_BITS'(vfc_pkg::PLANE_COUNT - 1));
   assign slot_ok  = ({1'b0, cmd.slot} < (vfc_pkg::SLOT_BITS + 1)'(vfc_pkg::PLANE_COUNT));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vfc_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd.op == vfc_pkg::OP_TEST) ? vfc_pkg::BK_RUN : vfc_pkg::BK_OUT;
            end
         end
         vfc_pkg::BK_RUN: begin
            if (last_idx) begin
               state_in = vfc_pkg::BK_DRAIN;
            end
         end
         vfc_pkg::BK_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = vfc_pkg::BK_OUT;
            end
         end
         vfc_pkg::BK_OUT: begin
            if (rsp.ready) begin
               state_in = vfc_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = vfc_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop   = 1'b0;
      issue     = 1'b0;
      rsp.valid = 1'b0;
      case (state_ff)
         vfc_pkg::BK_IDLE:  cmd_pop   = cmd_valid;
         vfc_pkg::BK_RUN:   issue     = 1'b1;
         vfc_pkg::BK_OUT:   rsp.valid = 1'b1;
         default: begin
         end
      endcase
   end

   assign rsp.visible = vis_ff;

   // corner that maximizes the distance: step along the sign of each normal term
   always_comb begin
      pl    = tab_ff[idx_ff];
      px_in = pl.a[C-1] ? ($signed({job_ff.cx[C-1], job_ff.cx}) - $signed({2'b00, job_ff.hx}))
                        : ($signed({job_ff.cx[C-1], job_ff.cx}) + $signed({2'b00, job_ff.hx}));
      py_in = pl.b[C-1] ? ($signed({job_ff.cy[C-1], job_ff.cy}) - $signed({2'b00, job_ff.hy}))
                        : ($signed({job_ff.cy[C-1], job_ff.cy}) + $signed({2'b00, job_ff.hy}));
      pz_in = pl.c[C-1] ? ($signed({job_ff.cz[C-1], job_ff.cz}) - $signed({2'b00, job_ff.hz}))
                        : ($signed({job_ff.cz[C-1], job_ff.cz}) + $signed({2'b00, job_ff.hz}));
      off_in = (S'(pl.d) <<< vfc_pkg::DSHIFT)
             + $signed(S'({1'b0, job_ff.radius}) << vfc_pkg::DSHIFT);
   end

   assign dist_sum = S'(s2_p0_ff) + S'(s2_p1_ff) + S'(s2_p2_ff) + s2_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= vfc_pkg::BK_IDLE;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         idx_ff    <= '0;
         vis_ff    <= 1'b0;
         for (int i = 0; i < vfc_pkg::PLANE_COUNT; i++) begin
            tab_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         if (cmd_pop) begin
            idx_ff <= '0;
            vis_ff <= (cmd.op == vfc_pkg::OP_TEST);
            if (cmd.op == vfc_pkg::OP_LOAD && slot_ok) begin
               tab_ff[vfc_pkg::IDX_BITS'(cmd.slot)] <= cmd.plane;
            end
         end else begin
            // index parks on the last plane so the table is never read out of range
            if (issue && !last_idx) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (s2_vld_ff) begin
               vis_ff <= vis_ff & ~dist_sum[S-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         job_ff <= cmd;
      end
      s1_a_ff   <= pl.a;
      s1_b_ff   <= pl.b;
      s1_c_ff   <= pl.c;
      s1_px_ff  <= px_in;
      s1_py_ff  <= py_in;
      s1_pz_ff  <= pz_in;
      s1_off_ff <= off_in;
      s2_p0_ff  <= P'(s1_a_ff) * P'(s1_px_ff);
      s2_p1_ff  <= P'(s1_b_ff) * P'(s1_py_ff);
      s2_p2_ff  <= P'(s1_c_ff) * P'(s1_pz_ff);
      s2_off_ff <= s1_off_ff;
   end

endmodule

// ----- rtl/view_frustum_culling_test.sv -----
// top level of the six-plane view frustum culling test
// a test beat walks all PLANE_COUNT planes in the back part:
// one plane a cycle through the three-multiplier distance unit, then the s1 and s2 stages drain
// load and unused-mode beats skip the plane walk and go straight to the response state;
// while the back part is busy, the 2-entry command queue keeps taking beats until it is full
// synchronous reset clears the plane table to zero, the queue and the sequencer
module view_frustum_culling_test (
   input logic     clock,
   input logic     reset,
   vfc_req_if.sink req_ch,
   vfc_rsp_if.source rsp_ch
);

   // command queue between classifier and plane sequencer
   vfc_pkg::cmd_type cmd;
   logic             cmd_valid;
   logic             cmd_pop;

   // front: decodes the mode into a test, load or no-op command
   vfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // back: loads the plane table, walks the planes and holds the response beat
   vfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_ch)
   );

   // the back part never takes from an empty queue
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop from empty command queue");

   // a load answers at once with an invisible result
   a_load_answer: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.op == vfc_pkg::OP_LOAD) |=> (rsp_ch.valid && !rsp_ch.visible))
      else $error("load beat did not answer with visible low");

   // a test starts the plane walk, no response in the next cycle
   a_test_walks: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.op == vfc_pkg::OP_TEST) |=> !rsp_ch.valid)
      else $error("test beat answered before the plane walk");

endmodule

// ----- bench/vfc_bench_if.sv -----
// no extra interfaces needed beyond the rtl ones; this file holds the bench item type
package vfc_bench_pkg;
   import vfc_pkg::*;

   typedef struct {
      logic [MODE_BITS-1:0]         mode;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
      logic [HALF_BITS-1:0]         hx;
      logic [HALF_BITS-1:0]         hy;
      logic [HALF_BITS-1:0]         hz;
      logic [SLOT_BITS-1:0]         slot;
      logic signed [COORD_BITS-1:0] pa;
      logic signed [COORD_BITS-1:0] pb;
      logic signed [COORD_BITS-1:0] pc;
      logic signed [COORD_BITS-1:0] pd;
   } cull_item_type;
endpackage

// ----- bench/view_frustum_culling_test_test.sv -----
// testbench of the view frustum culling test: directed and random beats checked against a plane-table predictor
module view_frustum_culling_test_test;
   timeunit 1ns;
   timeprecision 1ps;
   import vfc_pkg::*;
   import vfc_bench_pkg::*;

   logic clock;
   logic reset;
   vfc_req_if req_ch ();
   vfc_rsp_if rsp_ch ();

   view_frustum_culling_test i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // predictor copy of the plane table
   logic signed [COORD_BITS-1:0] tab_a[PLANE_COUNT];
   logic signed [COORD_BITS-1:0] tab_b[PLANE_COUNT];
   logic signed [COORD_BITS-1:0] tab_c[PLANE_COUNT];
   logic signed [COORD_BITS-1:0] tab_d[PLANE_COUNT];

   logic visible_queue[$];
   int   failures = 0;
   int   idle_cycles = 0;
   bit   hold_rsp = 0;     // long receiver hold-off
   bit   fast_rsp = 0;     // stretch with no stalls
   bit   fast_req = 0;
   bit   offering = 0;     // request valid currently driven high

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // exact signed distance, wide enough for three Q2.30 x Q17.16 products plus terms
   function automatic bit corner_passes(int p, logic signed [35:0] px,
                                        logic signed [35:0] py, logic signed [35:0] pz,
                                        logic signed [127:0] extra);
      logic signed [127:0] sum;
      sum = 128'(tab_a[p]) * 128'(px) + 128'(tab_b[p]) * 128'(py)
          + 128'(tab_c[p]) * 128'(pz) + (128'(tab_d[p]) <<< 30) + extra;
      return sum >= 0;
   endfunction

   function automatic bit predict_visible(cull_item_type it);
      bit vis;
      bit any;
      logic signed [35:0] cx, cy, cz, hx, hy, hz;
      vis = 1;
      cx = 36'(it.cx); cy = 36'(it.cy); cz = 36'(it.cz);
      hx = {5'b0, it.hx};
      hy = (it.mode == MODE_BOX) ? {5'b0, it.hy} : hx;
      hz = (it.mode == MODE_BOX) ? {5'b0, it.hz} : hx;
      if (it.mode == MODE_LOAD) begin
         if (it.slot < PLANE_COUNT) begin
            tab_a[it.slot] = it.pa;
            tab_b[it.slot] = it.pb;
            tab_c[it.slot] = it.pc;
            tab_d[it.slot] = it.pd;
         end
         return 0;
      end
      if (it.mode > MODE_LOAD) return 0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         case (it.mode)
            MODE_POINT: vis &= corner_passes(p, cx, cy, cz, 0);
            MODE_SPHERE: vis &= corner_passes(p, cx, cy, cz, 128'(hx) <<< 30);
            default: begin
               any = 0;
               for (int k = 0; k < 8; k++)
                  any |= corner_passes(p, k[0] ? cx + hx : cx - hx,
                                       k[1] ? cy + hy : cy - hy,
                                       k[2] ? cz + hz : cz - hz, 0);
               vis &= any;
            end
         endcase
      end
      return vis;
   endfunction

   // send one beat after a random gap; valid stays up for a back-to-back follower
   task automatic send_beat(cull_item_type it);
      int gap;
      gap = fast_req ? 0 : $urandom_range(0, 11);
      if (gap != 0 && offering) begin
         req_ch.valid <= 0;
         offering = 0;
      end
      repeat (gap) @(posedge clock);
      req_ch.valid      <= 1;
      req_ch.mode       <= it.mode;
      req_ch.center_x   <= it.cx;
      req_ch.center_y   <= it.cy;
      req_ch.center_z   <= it.cz;
      req_ch.half_x     <= it.hx;
      req_ch.half_y     <= it.hy;
      req_ch.half_z     <= it.hz;
      req_ch.plane_slot <= it.slot;
      req_ch.plane_a    <= it.pa;
      req_ch.plane_b    <= it.pb;
      req_ch.plane_c    <= it.pc;
      req_ch.plane_d    <= it.pd;
      offering = 1;
      // ready is registered, so its mid-cycle value decides the coming edge
      forever begin
         @(negedge clock);
         if (req_ch.ready) break;
      end
      @(posedge clock);
      visible_queue.push_back(predict_visible(it));
   endtask

   task automatic stop_offer();
      if (offering) begin
         req_ch.valid <= 0;
         offering = 0;
      end
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 0;
         3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic cull_item_type rand_test(int mode);
      cull_item_type it;
      it.mode = mode[2:0];
      it.cx = rand_word(); it.cy = rand_word(); it.cz = rand_word();
      it.hx = ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                          : 31'($urandom_range(0, 32'h0004_0000));
      it.hy = ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                          : 31'($urandom_range(0, 32'h0004_0000));
      it.hz = ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                          : 31'($urandom_range(0, 32'h0004_0000));
      it.slot = 3'($urandom()); it.pa = $urandom(); it.pb = $urandom();
      it.pc = $urandom(); it.pd = $urandom();
      return it;
   endfunction

   // roughly normalized plane so that tests split between visible and culled
   function automatic cull_item_type rand_load(int slot);
      cull_item_type it;
      it = rand_test(MODE_LOAD);
      it.slot = slot[2:0];
      if ($urandom_range(0, 4) != 0) begin
         it.pa = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
         it.pb = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
         it.pc = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
         it.pd = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      end
      return it;
   endfunction

   task automatic wait_drained();
      while (visible_queue.size() != 0) @(posedge clock);
   endtask

   // extremes, every mode, cleared table, bad slot, unused modes
   task automatic test_directed();
      cull_item_type it;
      for (int m = 0; m < 8; m++) begin
         it = rand_test(m);      // cleared table passes everything
         send_beat(it);
      end
      it = rand_load(PLANE_COUNT); send_beat(it);
      it = rand_load(7); send_beat(it);
      it = rand_load(0);
      it.pa = 32'h7fff_ffff; it.pb = 32'h8000_0000; it.pc = 32'h7fff_ffff;
      it.pd = 32'h8000_0000;
      send_beat(it);
      for (int m = 0; m < 4; m++) begin
         it = rand_test(m);
         it.cx = 32'h8000_0000; it.cy = 32'h7fff_ffff; it.cz = 32'h8000_0000;
         it.hx = '1; it.hy = '1; it.hz = '1;
         send_beat(it);
         it.hx = 0; it.hy = 0; it.hz = 0; it.cx = 32'h7fff_ffff;
         send_beat(it);
      end
      stop_offer();
   endtask

   // mostly well-formed: occasional plane reloads and rare unused modes among the tests
   task automatic test_random(int count);
      cull_item_type it;
      int n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) == 0) it = rand_load($urandom_range(0, 7));
         else if ($urandom_range(0, 19) == 0) it = rand_test($urandom_range(5, 7));
         else it = rand_test($urandom_range(0, 3));
         send_beat(it);
         n++;
      end
      stop_offer();
   endtask

   // receiver holds off for a long stretch while beats keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            fast_req = 1;
            test_random(12);
            fast_req = 0;
         end
      join
      wait_drained();
   endtask

   task automatic test_full_rate();
      fast_req = 1; fast_rsp = 1;
      for (int s = 0; s < PLANE_COUNT; s++) send_beat(rand_load(s));
      test_random(30);
      fast_req = 0; fast_rsp = 0;
   endtask

   // response side: random ready, check each beat against the oldest prediction
   initial begin
      int gap;
      logic got;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         gap = fast_rsp ? 0 : $urandom_range(0, 11);
         if (gap != 0 || hold_rsp) begin
            rsp_ch.ready <= 0;
            repeat (gap) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         // valid is registered, so its mid-cycle value decides the coming edge
         forever begin
            @(negedge clock);
            if (rsp_ch.valid) break;
         end
         got = rsp_ch.visible;
         @(posedge clock);
         if (visible_queue.size() == 0) begin
            $error("unexpected response beat, visible=%0b", got);
            failures++;
         end else begin
            logic want;
            want = visible_queue.pop_front();
            if (got !== want) begin
               $error("visible: expected %0b actual %0b", want, got);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      foreach (tab_a[p]) begin
         tab_a[p] = 0; tab_b[p] = 0; tab_c[p] = 0; tab_d[p] = 0;
      end
      reset = 1;
      req_ch.valid = 0; req_ch.mode = 0;
      req_ch.center_x = 0; req_ch.center_y = 0; req_ch.center_z = 0;
      req_ch.half_x = 0; req_ch.half_y = 0; req_ch.half_z = 0;
      req_ch.plane_slot = 0; req_ch.plane_a = 0; req_ch.plane_b = 0;
      req_ch.plane_c = 0; req_ch.plane_d = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_full_rate();
      wait_drained();    // sender pauses until every result is back
      test_random(380);
      wait_drained();
      repeat (30) @(posedge clock);
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
